>>> rtl/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

  // Field widths fixed by the frame and result formats.
  localparam int unsigned POS_CODE_W  = 16;
  localparam int unsigned VT_CODE_W   = 12;
  localparam int unsigned FULL_W      = 24;
  localparam int unsigned VALUE_W     = 25;
  localparam int unsigned TOTAL_OUT_W = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned NODE_W      = 4;
  localparam int unsigned BUS_W       = 2;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 4'd6;

  localparam logic [NODE_W-1:0] NODE_ID_RST    = 4'd1;
  localparam logic [BUS_W-1:0]  BUS_INDEX_RST  = 2'd0;
  localparam logic [FULL_W-1:0] ANGLE_MAX_RST  = 24'd819200;
  localparam logic [FULL_W-1:0] OMEGA_MAX_RST  = 24'd3276800;
  localparam logic [FULL_W-1:0] TORQUE_MAX_RST = 24'd1179648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ID    = 3'd0,
    REG_BUS_INDEX  = 3'd1,
    REG_ANGLE_MAX  = 3'd2,
    REG_OMEGA_MAX  = 3'd3,
    REG_TORQUE_MAX = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic fold;
    logic finish;
    logic delta;
    logic accum;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/mfd_lane.sv
`timescale 1ns / 1ps

// Maps one code onto [-full, +full]: round(2*code*full / (2^CODE_W - 1)) - full.
// The division by 2^CODE_W - 1 is done by folding the high part onto the low
// part, one fold per cycle, then a single compare and correct.
module mfd_lane #(
  parameter int unsigned CODE_W = 16
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 fold,
  input  logic                                 finish,
  input  logic [CODE_W-1:0]                    code,
  input  logic [mfd_pkg::FULL_W-1:0]           full,
  output logic signed [mfd_pkg::VALUE_W-1:0]   value
);

  localparam int unsigned N_W    = CODE_W + mfd_pkg::FULL_W + 1;
  localparam int unsigned PROD_W = CODE_W + mfd_pkg::FULL_W;
  localparam int unsigned HI_W   = N_W - CODE_W;
  localparam int unsigned Q_W    = mfd_pkg::FULL_W + 2;
  localparam logic [N_W-1:0] DIVISOR = N_W'((64'd1 << CODE_W) - 64'd1);
  localparam logic [N_W-1:0] HALF    = N_W'((64'd1 << (CODE_W - 1)) - 64'd1);

  logic [N_W-1:0]            n_r, n_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic signed [mfd_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [PROD_W-1:0]         prod;
  logic [HI_W-1:0]           hi_part;
  logic [CODE_W-1:0]         lo_part;
  logic [Q_W-1:0]            q_final;

  assign prod    = PROD_W'(code) * PROD_W'(full);
  assign hi_part = n_r[N_W-1:CODE_W];
  assign lo_part = n_r[CODE_W-1:0];
  assign q_final = q_r + Q_W'(n_r >= DIVISOR) - Q_W'(full);

  always_comb begin
    n_nxt     = n_r;
    q_nxt     = q_r;
    value_nxt = value_r;
    if (load) begin
      n_nxt = {prod, 1'b0} + HALF;
      q_nxt = '0;
    end else if (fold) begin
      // n = hi*2^CODE_W + lo = hi*DIVISOR + (hi + lo)
      n_nxt = N_W'(hi_part) + N_W'(lo_part);
      q_nxt = q_r + Q_W'(hi_part);
    end else if (finish) begin
      value_nxt = q_final[mfd_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

>>> rtl/mfd_dp.sv
`timescale 1ns / 1ps

module mfd_dp #(
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mfd_pkg::dp_cmd_t                        cmd,
  output mfd_pkg::dp_status_t                     status,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_standard_id,
  input  logic                                    in_data_frame,
  input  logic [mfd_pkg::LEN_W-1:0]               in_frame_length,
  input  logic [7:0]                              in_id_byte,
  input  logic [7:0]                              in_position_high,
  input  logic [7:0]                              in_position_low,
  input  logic [7:0]                              in_velocity_high,
  input  logic [7:0]                              in_velocity_torque_mix,
  input  logic [7:0]                              in_torque_low,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mfd_pkg::BUS_W-1:0]               out_bus_tag,
  output logic [mfd_pkg::NODE_W-1:0]              out_motor_id,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_angle,
  output logic signed [mfd_pkg::TOTAL_OUT_W-1:0]  out_total_angle,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_velocity,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_torque
);

  localparam int unsigned DELTA_W = mfd_pkg::VALUE_W + 2;
  localparam logic signed [TOTAL_WIDTH-1:0] SMAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
  localparam logic signed [TOTAL_WIDTH-1:0] SMIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [mfd_pkg::NODE_W-1:0] node_id_r;
  logic [mfd_pkg::BUS_W-1:0]  bus_index_r;
  logic [mfd_pkg::FULL_W-1:0] angle_max_r, omega_max_r, torque_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= mfd_pkg::NODE_ID_RST;
      bus_index_r  <= mfd_pkg::BUS_INDEX_RST;
      angle_max_r  <= mfd_pkg::ANGLE_MAX_RST;
      omega_max_r  <= mfd_pkg::OMEGA_MAX_RST;
      torque_max_r <= mfd_pkg::TORQUE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfd_pkg::REG_NODE_ID:    node_id_r    <= cfg_data[mfd_pkg::NODE_W-1:0];
        mfd_pkg::REG_BUS_INDEX:  bus_index_r  <= cfg_data[mfd_pkg::BUS_W-1:0];
        mfd_pkg::REG_ANGLE_MAX:  angle_max_r  <= cfg_data;
        mfd_pkg::REG_OMEGA_MAX:  omega_max_r  <= cfg_data;
        mfd_pkg::REG_TORQUE_MAX: torque_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame filter.
  assign status.frame_ok = in_standard_id && in_data_frame &&
                           (in_frame_length >= mfd_pkg::MIN_FRAME_LEN) &&
                           (in_id_byte[mfd_pkg::NODE_W-1:0] == node_id_r);

  logic [mfd_pkg::POS_CODE_W-1:0] pos_code;
  logic [mfd_pkg::VT_CODE_W-1:0]  vel_code, trq_code;
  logic signed [mfd_pkg::VALUE_W-1:0] ang_val, vel_val, trq_val;

  assign pos_code = {in_position_high, in_position_low};
  assign vel_code = {in_velocity_high, in_velocity_torque_mix[7:4]};
  assign trq_code = {in_velocity_torque_mix[3:0], in_torque_low};

  mfd_lane #(.CODE_W(mfd_pkg::POS_CODE_W)) u_pos_lane (
    .clk(clk), .load(cmd.load), .fold(cmd.fold), .finish(cmd.finish),
    .code(pos_code), .full(angle_max_r), .value(ang_val)
  );

  mfd_lane #(.CODE_W(mfd_pkg::VT_CODE_W)) u_vel_lane (
    .clk(clk), .load(cmd.load), .fold(cmd.fold), .finish(cmd.finish),
    .code(vel_code), .full(omega_max_r), .value(vel_val)
  );

  mfd_lane #(.CODE_W(mfd_pkg::VT_CODE_W)) u_trq_lane (
    .clk(clk), .load(cmd.load), .fold(cmd.fold), .finish(cmd.finish),
    .code(trq_code), .full(torque_max_r), .value(trq_val)
  );

  // Unwrap state.
  logic                            seeded_r;
  logic signed [mfd_pkg::VALUE_W-1:0] prev_angle_r;
  logic signed [TOTAL_WIDTH-1:0]   acc_r;
  logic signed [DELTA_W-1:0]       delta_r;
  logic signed [DELTA_W-1:0]       diff, amax_s, two_amax_s, delta_nxt;
  logic signed [TOTAL_WIDTH:0]     sum;
  logic signed [TOTAL_WIDTH-1:0]   acc_sum_sat;
  logic signed [63:0]              acc_wide;

  assign diff       = DELTA_W'(ang_val) - DELTA_W'(prev_angle_r);
  assign amax_s     = DELTA_W'(angle_max_r);
  assign two_amax_s = DELTA_W'({angle_max_r, 1'b0});

  always_comb begin
    if (diff > amax_s) begin
      delta_nxt = diff - two_amax_s;
    end else if (diff < -amax_s) begin
      delta_nxt = diff + two_amax_s;
    end else begin
      delta_nxt = diff;
    end
  end

  assign sum = (TOTAL_WIDTH+1)'(acc_r) + (TOTAL_WIDTH+1)'(delta_r);

  always_comb begin
    if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
      acc_sum_sat = sum[TOTAL_WIDTH] ? SMIN : SMAX;
    end else begin
      acc_sum_sat = sum[TOTAL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      delta_r <= delta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r     <= 1'b0;
      prev_angle_r <= '0;
      acc_r        <= '0;
    end else if (cmd.accum) begin
      seeded_r     <= 1'b1;
      prev_angle_r <= ang_val;
      acc_r        <= seeded_r ? acc_sum_sat : TOTAL_WIDTH'(ang_val);
    end
  end

  // The result field is the running total sign-extended or cut to 48 bits.
  assign acc_wide = 64'(acc_r);

  // Output register.
  logic out_valid_r;

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_bus_tag     <= bus_index_r;
      out_motor_id    <= node_id_r;
      out_angle       <= ang_val;
      out_total_angle <= acc_wide[mfd_pkg::TOTAL_OUT_W-1:0];
      out_velocity    <= vel_val;
      out_torque      <= trq_val;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/mfd_ctrl.sv
`timescale 1ns / 1ps

module mfd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mfd_pkg::dp_status_t  status,
  output mfd_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD1,
    ST_FOLD2,
    ST_FOLD3,
    ST_FINISH,
    ST_DELTA,
    ST_ACCUM,
    ST_PUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // Frames that fail the filter are taken and dropped here.
        if (in_valid && status.frame_ok) begin
          state_nxt = ST_FOLD1;
        end
      end
      ST_FOLD1:  state_nxt = ST_FOLD2;
      ST_FOLD2:  state_nxt = ST_FOLD3;
      ST_FOLD3:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_DELTA;
      ST_DELTA:  state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && in_valid && status.frame_ok;
    cmd.fold   = state_r inside {ST_FOLD1, ST_FOLD2, ST_FOLD3};
    cmd.finish = (state_r == ST_FINISH);
    cmd.delta  = (state_r == ST_DELTA);
    cmd.accum  = (state_r == ST_ACCUM);
    cmd.push   = (state_r == ST_PUSH) && status.out_free;
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

>>> rtl/motor_feedback_decode_unwrap_core.sv
// Flow: an accepted frame goes through the three-fold constant division in the
// mapping lanes, the finish step and the two-step unwrap, then is pushed once
// the previous result has left the output register. No new frame is taken until
// the push; a frame that fails the filter is taken and dropped in idle state.
// Reset (rst_n, synchronous): registers take their default values, the
// multi-turn total clears and the next accepted frame seeds it.
`timescale 1ns / 1ps

module motor_feedback_decode_unwrap_core #(
  parameter int unsigned TOTAL_WIDTH = 48
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_standard_id,
  input  logic                                    in_data_frame,
  input  logic [mfd_pkg::LEN_W-1:0]               in_frame_length,
  input  logic [7:0]                              in_id_byte,
  input  logic [7:0]                              in_position_high,
  input  logic [7:0]                              in_position_low,
  input  logic [7:0]                              in_velocity_high,
  input  logic [7:0]                              in_velocity_torque_mix,
  input  logic [7:0]                              in_torque_low,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mfd_pkg::BUS_W-1:0]               out_bus_tag,
  output logic [mfd_pkg::NODE_W-1:0]              out_motor_id,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_angle,
  output logic signed [mfd_pkg::TOTAL_OUT_W-1:0]  out_total_angle,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_velocity,
  output logic signed [mfd_pkg::VALUE_W-1:0]      out_torque
);

  mfd_pkg::dp_cmd_t    cmd;
  mfd_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mfd_dp #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_standard_id         (in_standard_id),
    .in_data_frame          (in_data_frame),
    .in_frame_length        (in_frame_length),
    .in_id_byte             (in_id_byte),
    .in_position_high       (in_position_high),
    .in_position_low        (in_position_low),
    .in_velocity_high       (in_velocity_high),
    .in_velocity_torque_mix (in_velocity_torque_mix),
    .in_torque_low          (in_torque_low),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_bus_tag            (out_bus_tag),
    .out_motor_id           (out_motor_id),
    .out_angle              (out_angle),
    .out_total_angle        (out_total_angle),
    .out_velocity           (out_velocity),
    .out_torque             (out_torque)
  );

`ifndef NO_ASSERTIONS
  // A lane load happens only for an accepted frame that passes the filter.
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && in_ready && status.frame_ok))
    else $error("lane load without an accepted good frame");

  // Once a good frame is taken, no new item is taken in the next cycle.
  a_busy_after_good: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.frame_ok) |=> !in_ready)
    else $error("input taken while a frame is in work");

  // A result is never written over one that has not been delivered.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> status.out_free)
    else $error("output register overwritten");

  // A new result appears only from a push in the cycle before.
  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.push))
    else $error("output valid without a push");
`endif

endmodule
